[rtl/rau_pkg.sv]
package rau_pkg;

  localparam int WIDTH = 32;
  localparam int DW = 2 * WIDTH;

  localparam logic [2:0] ACT_NORM = 3'd0;
  localparam logic [2:0] ACT_ADD  = 3'd1;
  localparam logic [2:0] ACT_SUB  = 3'd2;
  localparam logic [2:0] ACT_MUL  = 3'd3;
  localparam logic [2:0] ACT_DIV  = 3'd4;
  localparam logic [2:0] ACT_CMP  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // Datapath register selectors.
  localparam logic [2:0] SEL_AN = 3'd0;
  localparam logic [2:0] SEL_AD = 3'd1;
  localparam logic [2:0] SEL_BN = 3'd2;
  localparam logic [2:0] SEL_BD = 3'd3;
  localparam logic [2:0] SEL_RN = 3'd4;
  localparam logic [2:0] SEL_RD = 3'd5;

  // Datapath operations.
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_GCD_LD  = 4'd2;  // x = num(sel), y = den(sel)
  localparam logic [3:0] OP_MOD_ST  = 4'd3;  // start x % y
  localparam logic [3:0] OP_MOD_WB  = 4'd4;  // x = y, y = rem
  localparam logic [3:0] OP_DIV_NUM = 4'd5;  // start num / g
  localparam logic [3:0] OP_DIV_DEN = 4'd6;  // start den / g
  localparam logic [3:0] OP_WB_NUM  = 4'd7;
  localparam logic [3:0] OP_WB_DEN  = 4'd8;
  localparam logic [3:0] OP_MUL1    = 4'd9;  // start first product
  localparam logic [3:0] OP_MUL2    = 4'd10;
  localparam logic [3:0] OP_MUL3    = 4'd11;
  localparam logic [3:0] OP_COMBINE = 4'd12;
  localparam logic [3:0] OP_FINISH  = 4'd13;

  typedef struct packed {
    logic [2:0]        action;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         order;
    logic [1:0]         status;
  } rau_out_t;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] sel;
  } rau_cmd_t;

  typedef struct packed {
    logic unit_done;
    logic y_zero;
    logic num_zero;
    logic zero_err;
  } rau_stat_t;

endpackage

[rtl/rau_divider.sv]
module rau_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [rau_pkg::DW-1:0] dividend,
  input  logic [rau_pkg::DW-1:0] divisor,
  output logic                 done,
  output logic [rau_pkg::DW-1:0] quotient,
  output logic [rau_pkg::DW-1:0] remainder
);
  import rau_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]   shifted, diff;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[DW-1:0], q_r[DW-1]};
    diff     = shifted - {1'b0, d_r};
    if (start) begin
      q_nxt    = dividend;
      d_nxt    = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_nxt = diff;
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r[DW-1:0];

  assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider restarted while busy");
endmodule

[rtl/rau_datapath.sv]
module rau_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::rau_in_t  in_data,
  input  rau_pkg::rau_cmd_t cmd,
  output rau_pkg::rau_stat_t stat,
  output rau_pkg::rau_out_t out_data
);
  import rau_pkg::*;

  logic [DW-1:0] an_r, ad_r, bn_r, bd_r, rn_r, rd_r, x_r, y_r;
  logic [DW-1:0] an_nxt, ad_nxt, bn_nxt, bd_nxt, rn_nxt, rd_nxt, x_nxt, y_nxt;
  logic          aneg_r, bneg_r, rneg_r, aneg_nxt, bneg_nxt, rneg_nxt;
  logic [DW-1:0] p_r, q_r, p_nxt, q_nxt;
  logic [2:0]    act_r, act_nxt;
  logic          zerr_r, zerr_nxt;
  rau_out_t      out_r, out_nxt;

  logic          div_start;
  logic [DW-1:0] div_a, div_b, div_q, div_rem;
  logic          div_done;

  logic [WIDTH-1:0] mul_a, mul_b;
  logic [DW-1:0]    prod_r;
  logic             mul_go_r;

  logic [WIDTH-1:0] ln [4];
  logic [WIDTH-1:0] lmag [4];
  logic             lneg [4];
  logic [DW-1:0]    selnum, selden, lim;

  rau_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_rem)
  );

  assign lim = DW'(1) << (WIDTH - 1);

  always_comb begin
    ln[0] = in_data.a_num[WIDTH-1:0];
    ln[1] = in_data.a_den[WIDTH-1:0];
    ln[2] = in_data.b_num[WIDTH-1:0];
    ln[3] = in_data.b_den[WIDTH-1:0];
    for (int i = 0; i < 4; i++) begin
      lneg[i] = ln[i][WIDTH-1];
      lmag[i] = lneg[i] ? (~ln[i] + 1'b1) : ln[i];
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_AN: begin
        selnum = an_r;
        selden = ad_r;
      end
      SEL_BN: begin
        selnum = bn_r;
        selden = bd_r;
      end
      default: begin
        selnum = rn_r;
        selden = rd_r;
      end
    endcase
  end

  // Multiplier operands; the product is registered and available in the next cycle.
  always_comb begin
    case (cmd.op)
      OP_MUL1: begin
        mul_a = an_r[WIDTH-1:0];
        mul_b = (act_r == ACT_MUL) ? bn_r[WIDTH-1:0] : bd_r[WIDTH-1:0];
      end
      OP_MUL2: begin
        mul_a = (act_r == ACT_MUL || act_r == ACT_DIV) ? ad_r[WIDTH-1:0]
                                                       : bn_r[WIDTH-1:0];
        mul_b = (act_r == ACT_MUL) ? bd_r[WIDTH-1:0]
              : (act_r == ACT_DIV) ? bn_r[WIDTH-1:0] : ad_r[WIDTH-1:0];
      end
      default: begin
        mul_a = ad_r[WIDTH-1:0];
        mul_b = bd_r[WIDTH-1:0];
      end
    endcase
  end

  always_comb begin
    an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    rn_nxt = rn_r; rd_nxt = rd_r; x_nxt = x_r; y_nxt = y_r;
    aneg_nxt = aneg_r; bneg_nxt = bneg_r; rneg_nxt = rneg_r;
    p_nxt = p_r; q_nxt = q_r; act_nxt = act_r; zerr_nxt = zerr_r;
    out_nxt = out_r;
    div_start = 1'b0;
    div_a = x_r;
    div_b = y_r;
    case (cmd.op)
      OP_LOAD: begin
        act_nxt  = (in_data.action > ACT_CMP) ? ACT_NORM : in_data.action;
        an_nxt   = DW'(lmag[0]);
        ad_nxt   = DW'(lmag[1]);
        bn_nxt   = DW'(lmag[2]);
        bd_nxt   = DW'(lmag[3]);
        aneg_nxt = lneg[0] ^ lneg[1];
        bneg_nxt = lneg[2] ^ lneg[3];
        rn_nxt   = DW'(lmag[0]);
        rd_nxt   = DW'(lmag[1]);
        rneg_nxt = lneg[0] ^ lneg[1];
        if (in_data.action == ACT_NORM || in_data.action > ACT_CMP) begin
          zerr_nxt = (lmag[1] == '0);
        end else begin
          zerr_nxt = (lmag[1] == '0) || (lmag[3] == '0) ||
                     (in_data.action == ACT_DIV && lmag[2] == '0);
        end
      end
      OP_GCD_LD: begin
        x_nxt = selnum;
        y_nxt = selden;
      end
      OP_MOD_ST: begin
        div_start = 1'b1;
      end
      OP_MOD_WB: begin
        x_nxt = y_r;
        y_nxt = div_rem;
      end
      OP_DIV_NUM: begin
        div_start = 1'b1;
        div_a = selnum;
        div_b = x_r;
      end
      OP_DIV_DEN: begin
        div_start = 1'b1;
        div_a = selden;
        div_b = x_r;
      end
      OP_WB_NUM: begin
        case (cmd.sel)
          SEL_AN: an_nxt = div_q;
          SEL_BN: bn_nxt = div_q;
          default: rn_nxt = div_q;
        endcase
      end
      OP_WB_DEN: begin
        case (cmd.sel)
          SEL_AN: ad_nxt = div_q;
          SEL_BN: bd_nxt = div_q;
          default: rd_nxt = div_q;
        endcase
        if (cmd.sel == SEL_AN && an_r == '0) aneg_nxt = 1'b0;
        if (cmd.sel == SEL_BN && bn_r == '0) bneg_nxt = 1'b0;
        if (cmd.sel == SEL_RN && rn_r == '0) rneg_nxt = 1'b0;
      end
      OP_MUL2: begin
        p_nxt = prod_r;
      end
      OP_MUL3: begin
        q_nxt = prod_r;
      end
      OP_COMBINE: begin
        // prod_r holds ad*bd; for multiply and divide q_r holds the denominator.
        rd_nxt = prod_r;
        case (act_r)
          ACT_ADD, ACT_SUB: begin
            if (aneg_r == (bneg_r ^ (act_r == ACT_SUB && bn_r != '0))) begin
              rn_nxt   = p_r + q_r;
              rneg_nxt = aneg_r;
            end else if (p_r >= q_r) begin
              rn_nxt   = p_r - q_r;
              rneg_nxt = aneg_r;
            end else begin
              rn_nxt   = q_r - p_r;
              rneg_nxt = ~aneg_r;
            end
          end
          default: begin
            rn_nxt   = p_r;
            rd_nxt   = q_r;
            rneg_nxt = aneg_r ^ bneg_r;
          end
        endcase
      end
      OP_FINISH: begin
        out_nxt = '0;
        if (zerr_r) begin
          out_nxt.status = ST_ZERO;
        end else if (act_r == ACT_CMP) begin
          if (aneg_r != bneg_r) begin
            out_nxt.order = aneg_r ? ORD_LT : ORD_GT;
          end else if (p_r == q_r) begin
            out_nxt.order = ORD_EQ;
          end else if ((p_r < q_r) != aneg_r) begin
            out_nxt.order = ORD_LT;
          end else begin
            out_nxt.order = ORD_GT;
          end
        end else if (rd_r >= lim || (rneg_r ? (rn_r > lim) : (rn_r >= lim))) begin
          out_nxt.status = ST_OVF;
        end else begin
          out_nxt.res_num = rneg_r ? 32'(~rn_r + 1'b1) : 32'(rn_r);
          out_nxt.res_den = 31'(rd_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_go_r <= 1'b0;
    end else begin
      mul_go_r <= (cmd.op == OP_MUL1) || (cmd.op == OP_MUL2);
    end
    prod_r <= DW'(mul_a) * DW'(mul_b);
    an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt; bd_r <= bd_nxt;
    rn_r <= rn_nxt; rd_r <= rd_nxt; x_r <= x_nxt; y_r <= y_nxt;
    aneg_r <= aneg_nxt; bneg_r <= bneg_nxt; rneg_r <= rneg_nxt;
    p_r <= p_nxt; q_r <= q_nxt; act_r <= act_nxt; zerr_r <= zerr_nxt;
    out_r <= out_nxt;
  end

  assign stat.unit_done = div_done;
  assign stat.y_zero    = (y_r == '0);
  assign stat.num_zero  = (x_r == '0);
  assign stat.zero_err  = zerr_r;
  assign out_data       = out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
                   (cmd.op == OP_MUL2 || cmd.op == OP_MUL3) |-> mul_go_r)
    else $error("product taken without a preceding multiply");
endmodule

[rtl/rau_ctrl.sv]
module rau_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2:0]         action,
  input  rau_pkg::rau_stat_t stat,
  output rau_pkg::rau_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import rau_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_GLD    = 4'd2;
  localparam logic [3:0] S_GTEST  = 4'd3;
  localparam logic [3:0] S_GWAIT  = 4'd4;
  localparam logic [3:0] S_DNUM   = 4'd5;
  localparam logic [3:0] S_WNUM   = 4'd6;
  localparam logic [3:0] S_DDEN   = 4'd7;
  localparam logic [3:0] S_WDEN   = 4'd8;
  localparam logic [3:0] S_MUL1   = 4'd9;
  localparam logic [3:0] S_MUL2   = 4'd10;
  localparam logic [3:0] S_MUL3   = 4'd11;
  localparam logic [3:0] S_COMB   = 4'd12;
  localparam logic [3:0] S_FINISH = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [2:0] sel_r, sel_nxt;
  logic [2:0] act_r, act_nxt;
  logic       done_r, done_nxt;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    act_nxt   = act_r;
    done_nxt  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.sel   = sel_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          act_nxt   = (action > ACT_CMP) ? ACT_NORM : action;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.zero_err) begin
          state_nxt = S_FINISH;
        end else begin
          sel_nxt   = (act_r == ACT_NORM) ? SEL_RN : SEL_AN;
          state_nxt = S_GLD;
        end
      end
      S_GLD: begin
        cmd.op    = OP_GCD_LD;
        state_nxt = S_GTEST;
      end
      S_GTEST: begin
        if (stat.y_zero) begin
          // x holds the gcd; zero only when both values are zero.
          state_nxt = stat.num_zero ? S_WDEN : S_DNUM;
        end else begin
          cmd.op    = OP_MOD_ST;
          state_nxt = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (stat.unit_done) begin
          cmd.op    = OP_MOD_WB;
          state_nxt = S_GTEST;
        end
      end
      S_DNUM: begin
        cmd.op    = OP_DIV_NUM;
        state_nxt = S_WNUM;
      end
      S_WNUM: begin
        if (stat.unit_done) begin
          cmd.op    = OP_WB_NUM;
          state_nxt = S_DDEN;
        end
      end
      S_DDEN: begin
        cmd.op    = OP_DIV_DEN;
        state_nxt = S_WDEN;
      end
      S_WDEN: begin
        if (stat.unit_done || stat.num_zero) begin
          cmd.op = stat.num_zero ? OP_NONE : OP_WB_DEN;
          if (sel_r == SEL_AN) begin
            sel_nxt   = SEL_BN;
            state_nxt = S_GLD;
          end else if (sel_r == SEL_BN) begin
            state_nxt = S_MUL1;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_MUL1: begin
        cmd.op    = OP_MUL1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op    = OP_MUL2;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.op    = OP_MUL3;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        if (act_r == ACT_CMP) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.op    = OP_COMBINE;
          sel_nxt   = SEL_RN;
          state_nxt = S_GLD;
        end
      end
      S_FINISH: begin
        cmd.op    = OP_FINISH;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= SEL_AN;
      act_r   <= ACT_NORM;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      act_r   <= act_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = done_r;

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy)
    else $error("result strobe while a transaction is in progress");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_FINISH) |=> (state_r == S_OUT))
    else $error("finish skipped output stage");
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == S_OUT) |-> !done_r)
    else $error("double result strobe");
endmodule

[rtl/rational_arithmetic_unit.sv]
// Channel  | Ports                      | Handshake
// input    | start, busy, in_data       | taken when start && !busy
// result   | out_valid, out_data        | one-cycle strobe, always taken
//
// A single bit-serial 64-bit divider is shared by every gcd and quotient step.
// Between acceptance and the result strobe, a zero denominator skips reduction;
// normalize runs one reduction, compare two, and the other actions three.
// rst_n is synchronous and returns the controller to idle.
// The receiver cannot stall; busy drops in the cycle of the result strobe.
module rational_arithmetic_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  rau_pkg::rau_in_t in_data,
  output logic             out_valid,
  output rau_pkg::rau_out_t out_data
);
  import rau_pkg::*;

  rau_cmd_t  cmd;
  rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .action(in_data.action),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  rau_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .out_data(out_data)
  );
endmodule

[tb/tb_rational_arithmetic_unit.sv]
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  rau_in_t  in_data;
  logic     out_valid;
  rau_out_t out_data;

  rau_in_t  pending_ops[$];
  rau_out_t expected_results[$];
  int       mismatch_count;
  bit       drain_request;
  int       gap_left;

  rational_arithmetic_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  typedef struct {
    bit          neg;
    logic [63:0] n;
    logic [63:0] d;
  } frac_t;

  function automatic frac_t unpack_frac(logic [31:0] num, logic [31:0] den);
    frac_t f;
    f.n = num[31] ? {32'd0, -num} : {32'd0, num};
    f.d = den[31] ? {32'd0, -den} : {32'd0, den};
    f.neg = num[31] ^ den[31];
    return f;
  endfunction

  function automatic frac_t lowest_terms(frac_t f);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] t;
    x = f.n;
    y = f.d;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x != 0) begin
      f.n = f.n / x;
      f.d = f.d / x;
    end
    if (f.n == 0) f.neg = 1'b0;
    return f;
  endfunction

  function automatic frac_t frac_sum(frac_t a, frac_t b);
    frac_t       r;
    logic [63:0] p;
    logic [63:0] q;
    p = a.n * b.d;
    q = b.n * a.d;
    r.d = a.d * b.d;
    if (a.neg == b.neg) begin
      r.n = p + q;
      r.neg = a.neg;
    end else if (p >= q) begin
      r.n = p - q;
      r.neg = a.neg;
    end else begin
      r.n = q - p;
      r.neg = b.neg;
    end
    return lowest_terms(r);
  endfunction

  function automatic rau_out_t rational_result(rau_in_t op);
    rau_out_t    res;
    frac_t       a;
    frac_t       b;
    frac_t       r;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] lim;
    lim = 64'd1 << 31;
    res = '0;
    a = unpack_frac(op.a_num, op.a_den);
    b = unpack_frac(op.b_num, op.b_den);
    if (op.action == ACT_NORM || op.action > ACT_CMP) begin
      if (a.d == 0) begin
        res.status = ST_ZERO;
        return res;
      end
      r = lowest_terms(a);
    end else begin
      if (a.d == 0 || b.d == 0 || (op.action == ACT_DIV && b.n == 0)) begin
        res.status = ST_ZERO;
        return res;
      end
      a = lowest_terms(a);
      b = lowest_terms(b);
      case (op.action)
        ACT_CMP: begin
          x = a.n * b.d;
          y = b.n * a.d;
          if (a.neg != b.neg) res.order = a.neg ? ORD_LT : ORD_GT;
          else if (x == y) res.order = ORD_EQ;
          else if ((x < y) != a.neg) res.order = ORD_LT;
          else res.order = ORD_GT;
          res.status = ST_OK;
          return res;
        end
        ACT_ADD: r = frac_sum(a, b);
        ACT_SUB: begin
          b.neg = (b.n != 0) ? !b.neg : 1'b0;
          r = frac_sum(a, b);
        end
        ACT_MUL: begin
          r.n = a.n * b.n;
          r.d = a.d * b.d;
          r.neg = a.neg ^ b.neg;
          r = lowest_terms(r);
        end
        default: begin
          r.n = a.n * b.d;
          r.d = a.d * b.n;
          r.neg = a.neg ^ b.neg;
          r = lowest_terms(r);
        end
      endcase
    end
    if (r.d >= lim || (r.neg ? (r.n > lim) : (r.n >= lim))) begin
      res.status = ST_OVF;
      return res;
    end
    res.res_num = r.neg ? 32'(-r.n) : 32'(r.n);
    res.res_den = r.d[30:0];
    res.status = ST_OK;
    return res;
  endfunction

  // Operand values favor small numbers and corner values so reduction and
  // cancellation happen often, with full-range values mixed in.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'(-$signed($urandom_range(1, 3)));
      4, 5: return 32'($urandom_range(1, 60)) * ($urandom_range(0, 1) ? 32'd1 : -32'd1);
      6: return 32'($urandom_range(1, 65535)) * 32'($urandom_range(1, 12));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(logic [2:0] act, logic [31:0] an, logic [31:0] ad,
                          logic [31:0] bn, logic [31:0] bd);
    rau_in_t op;
    op.action = act;
    op.a_num = an;
    op.a_den = ad;
    op.b_num = bn;
    op.b_den = bd;
    pending_ops.push_back(op);
  endtask

  // Driver: a transaction is taken at an edge where start is high and busy low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= $urandom_range(0, 12);
    end else if (start && !busy) begin
      expected_results.push_back(rational_result(in_data));
      void'(pending_ops.pop_front());
      gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (pending_ops.size() > 0 && !drain_request && $urandom_range(0, 3) == 0) begin
        in_data <= pending_ops[0];
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() > 0 &&
                   !(drain_request && expected_results.size() > 0)) begin
        start <= 1'b1;
        in_data <= pending_ops[0];
      end
    end
  end

  // Monitor: every strobe is one result transaction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result num=%0d den=%0d order=%0d status=%0d",
                   out_data.res_num, out_data.res_den, out_data.order,
                   out_data.status);
      end else begin
        rau_out_t want;
        want = expected_results.pop_front();
        if (out_data !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("mismatch: expected num=%0d den=%0d order=%0d status=%0d,",
                   want.res_num, want.res_den, want.order, want.status);
            $display(" got num=%0d den=%0d order=%0d status=%0d",
                     out_data.res_num, out_data.res_den, out_data.order,
                     out_data.status);
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    mismatch_count = 0;
    drain_request = 1'b0;
    gap_left = 0;

    queue_op(ACT_NORM, 32'd6, 32'd4, 32'd0, 32'd0);
    queue_op(ACT_NORM, 32'd5, 32'd0, 32'd1, 32'd1);
    queue_op(ACT_NORM, 32'd0, -32'd7, 32'd0, 32'd0);
    queue_op(ACT_NORM, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd0);
    queue_op(ACT_NORM, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'd0);
    queue_op(ACT_NORM, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
    queue_op(3'd6, 32'd9, -32'd12, 32'd0, 32'd0);
    queue_op(3'd7, -32'd4, 32'd2, 32'd3, 32'd0);
    queue_op(ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    queue_op(ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd0);
    queue_op(ACT_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
    queue_op(ACT_ADD, 32'd1, 32'd2, -32'd1, 32'd2);
    queue_op(ACT_SUB, 32'd3, 32'd4, 32'd1, 32'd1);
    queue_op(ACT_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    queue_op(ACT_SUB, 32'd0, 32'd1, 32'd0, 32'd5);
    queue_op(ACT_MUL, 32'h8000_0000, 32'd1, -32'd1, 32'd1);
    queue_op(ACT_MUL, 32'd2, 32'd3, 32'd3, 32'd2);
    queue_op(ACT_MUL, 32'd1, 32'h7fff_ffff, 32'd1, 32'd2);
    queue_op(ACT_DIV, 32'd1, 32'd2, 32'd0, 32'd3);
    queue_op(ACT_DIV, 32'd2, 32'd3, -32'd4, 32'd9);
    queue_op(ACT_DIV, 32'd1, 32'd0, 32'd1, 32'd1);
    queue_op(ACT_CMP, 32'd1, 32'd2, 32'd2, 32'd4);
    queue_op(ACT_CMP, -32'd1, 32'd3, 32'd1, 32'd3);
    queue_op(ACT_CMP, -32'd1, 32'd3, -32'd1, 32'd2);
    queue_op(ACT_CMP, 32'd5, 32'd7, 32'd5, 32'd0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Let the directed items finish, then hold the sender until all results are in.
    wait (pending_ops.size() == 0);
    drain_request = 1'b1;
    wait (expected_results.size() == 0);
    drain_request = 1'b0;

    for (int i = 0; i < 1650; i++) begin
      if ($urandom_range(0, 7) == 0)
        queue_op(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom);
      else
        queue_op(3'($urandom_range(0, 5)), pick_value(), pick_value(), pick_value(),
                 pick_value());
      if (i == 800) begin
        wait (pending_ops.size() < 5);
        drain_request = 1'b1;
        wait (pending_ops.size() == 0 && expected_results.size() == 0);
        drain_request = 1'b0;
      end
    end

    wait (pending_ops.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
